>>> rtl/lcfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcfe_pkg: shared definitions for the LED color fade engine
// Sizes, command codes, the color type, the LED index reduction table and
// the per-channel slew step.
// ----------------------------------------------------------------------------
package lcfe_pkg;

	// Sizing
	localparam int NUM_LEDS      = 16;
	localparam int DEFAULT_LEVEL = 128;
	localparam int LED_IDX_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int CHAN_W        = 8;
	localparam int LED_OUT_W     = 6;
	localparam int OPCODE_W      = 3;

	typedef logic [LED_IDX_W-1:0] led_idx_t;
	typedef logic [CHAN_W-1:0]    chan_t;

	localparam led_idx_t LAST_LED = led_idx_t'(NUM_LEDS - 1);

	// Command codes
	localparam logic [OPCODE_W-1:0] OP_SET_TGT  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_SET_IMM  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_FILL_TGT = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_FILL_IMM = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_LEVEL    = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_TICK     = 3'd5;

	// One RGB color as stored in the color memories
	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} rgb_t;

	localparam int RGB_W = $bits(rgb_t);

	// LED number reduction: 8-bit LED number to LED index, built by counting
	typedef led_idx_t idx_tbl_t [256];

	function automatic idx_tbl_t build_idx_tbl();
		idx_tbl_t tbl;
		led_idx_t r;
		r = '0;
		for (int i = 0; i < 256; i++) begin
			tbl[i] = r;
			if (r == LAST_LED) begin
				r = '0;
			end else begin
				r = led_idx_t'(r + 1'b1);
			end
		end
		return tbl;
	endfunction

	localparam idx_tbl_t IDX_TBL = build_idx_tbl();

	// Move one channel toward its target by at most step, never past it
	function automatic chan_t approach(input chan_t cur, input chan_t tgt, input chan_t step);
		logic [CHAN_W:0] up;
		logic [CHAN_W:0] tgt_plus;
		chan_t res;
		up       = {1'b0, cur} + {1'b0, step};
		tgt_plus = {1'b0, tgt} + {1'b0, step};
		res      = cur;
		if (cur < tgt) begin
			res = (up < {1'b0, tgt}) ? up[CHAN_W-1:0] : tgt;
		end else if (cur > tgt) begin
			res = ({1'b0, cur} > tgt_plus) ? chan_t'(cur - step) : tgt;
		end
		return res;
	endfunction

endpackage : lcfe_pkg
`default_nettype wire

>>> rtl/lcfe_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcfe_if: channel interfaces of the LED color fade engine
// Command, frame and fade step channels, each with valid/ready handshake.
// ----------------------------------------------------------------------------

// Command channel
interface lcfe_cmd_if;
	import lcfe_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [7:0]          led_index;
	chan_t               red_in;
	chan_t               green_in;
	chan_t               blue_in;
	chan_t               brightness_in;

	modport source (output valid, output opcode, output led_index, output red_in,
		output green_in, output blue_in, output brightness_in, input ready);
	modport sink (input valid, input opcode, input led_index, input red_in,
		input green_in, input blue_in, input brightness_in, output ready);
endinterface : lcfe_cmd_if

// Frame channel, one transaction per LED
interface lcfe_frm_if;
	import lcfe_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [LED_OUT_W-1:0] led_out;
	chan_t                red_out;
	chan_t                green_out;
	chan_t                blue_out;
	chan_t                level_out;
	logic                 frame_end;

	modport source (output valid, output led_out, output red_out, output green_out,
		output blue_out, output level_out, output frame_end, input ready);
	modport sink (input valid, input led_out, input red_out, input green_out,
		input blue_out, input level_out, input frame_end, output ready);
endinterface : lcfe_frm_if

// Fade step register write channel
interface lcfe_cfg_if;
	import lcfe_pkg::*;
	logic  valid;
	logic  ready;
	chan_t fade_step;

	modport source (output valid, output fade_step, input ready);
	modport sink (input valid, input fade_step, output ready);
endinterface : lcfe_cfg_if
`default_nettype wire

>>> rtl/lcfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcfe_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lcfe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule : lcfe_ram
`default_nettype wire

>>> rtl/led_color_fade_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_color_fade_engine: per-LED RGB slew-rate limiter
// Target and current colors live in two RAMs; a tick walks every LED,
// steps its current color toward the target and, if anything changed, streams out the frame.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                            
//  cmd      in   opcode, led_index, red/green/blue_in, brightness_in
//  frm      out  led_out, red/green/blue_out, level_out, frame_end   
//  cfg      in   fade_step                                           
//
//  Set target, set immediate, brightness: handled in the idle state as the command is taken.
//  Fill: one LED written per cycle in the fill state, over every LED.
//  Tick: a read-modify-write sweep over every LED, then, if a frame goes out, one
//  LED per cycle while frm.ready allows, through the read port of the current RAM.
//  Reset clears per-LED valid bits, so both RAMs read as black at once.
//  frm.ready low holds the frame sweep; cmd is taken only when idle.
//
module led_color_fade_engine (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lcfe_cmd_if.sink    cmd,
	lcfe_cfg_if.sink    cfg,
	lcfe_frm_if.source  frm
);
	import lcfe_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FILL = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t              state_q;
	led_idx_t            ptr_q;
	logic                iss_done_q;
	logic                pend_s1;
	led_idx_t            addr_s1;
	logic                tgt_vld_s1;
	logic                cur_vld_s1;
	logic [NUM_LEDS-1:0] tgt_vld_q;
	logic [NUM_LEDS-1:0] cur_vld_q;
	rgb_t                fill_rgb_q;
	logic                fill_cur_q;
	logic                dirty_q;
	logic                changed_q;
	chan_t               level_q;
	chan_t               step_q;

	// Output register
	logic                 frm_valid_q;
	logic [LED_OUT_W-1:0] led_out_q;
	rgb_t                 rgb_out_q;
	chan_t                level_out_q;
	logic                 frame_end_q;

	// RAM ports
	logic     tgt_we;
	led_idx_t tgt_waddr;
	rgb_t     tgt_wdata;
	logic     cur_we;
	led_idx_t cur_waddr;
	rgb_t     cur_wdata;
	led_idx_t raddr;
	rgb_t     tgt_rdata;
	rgb_t     cur_rdata;

	logic     cmd_acc;
	led_idx_t cmd_idx;
	rgb_t     cmd_rgb;
	rgb_t     tgt_eff;
	rgb_t     cur_eff;
	rgb_t     cur_next;
	logic     differs;
	logic     issue;
	logic     load;

	// Handshakes and command decode
	assign cmd.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd_idx   = IDX_TBL[cmd.led_index];
	assign cmd_rgb   = {cmd.red_in, cmd.green_in, cmd.blue_in};

	// Never-written entries read as black
	assign tgt_eff = tgt_vld_s1 ? tgt_rdata : '0;
	assign cur_eff = cur_vld_s1 ? cur_rdata : '0;

	// Slew step for the entry read last cycle
	assign cur_next.r = approach(cur_eff.r, tgt_eff.r, step_q);
	assign cur_next.g = approach(cur_eff.g, tgt_eff.g, step_q);
	assign cur_next.b = approach(cur_eff.b, tgt_eff.b, step_q);
	assign differs    = (cur_eff != tgt_eff);

	// Frame output takes the pending read when the output register frees
	assign load = (state_q == ST_EMIT) && pend_s1 && (!frm_valid_q || frm.ready);

	// Read issue: free-running in the sweep, flow-controlled in the frame
	always_comb begin
		issue = 1'b0;
		if (state_q == ST_SCAN) begin
			issue = !iss_done_q;
		end else if (state_q == ST_EMIT) begin
			issue = !iss_done_q && (!pend_s1 || load);
		end
	end

	// Stalled frame reads repeat the held address so read data stays put
	assign raddr = ((state_q == ST_EMIT) && !issue) ? addr_s1 : ptr_q;

	// Target RAM write port
	always_comb begin
		tgt_we    = (state_q == ST_FILL) ||
			(cmd_acc && ((cmd.opcode == OP_SET_TGT) || (cmd.opcode == OP_SET_IMM)));
		tgt_waddr = (state_q == ST_FILL) ? ptr_q : cmd_idx;
		tgt_wdata = (state_q == ST_FILL) ? fill_rgb_q : cmd_rgb;
	end

	// Current RAM write port
	always_comb begin
		cur_we = ((state_q == ST_SCAN) && pend_s1) ||
			((state_q == ST_FILL) && fill_cur_q) ||
			(cmd_acc && (cmd.opcode == OP_SET_IMM));
		if (state_q == ST_SCAN) begin
			cur_waddr = addr_s1;
			cur_wdata = cur_next;
		end else if (state_q == ST_FILL) begin
			cur_waddr = ptr_q;
			cur_wdata = fill_rgb_q;
		end else begin
			cur_waddr = cmd_idx;
			cur_wdata = cmd_rgb;
		end
	end

	lcfe_ram #(
		.WIDTH (RGB_W),
		.DEPTH (NUM_LEDS)
	) u_tgt_ram (
		.clk     (clk),
		.wr_en   (tgt_we),
		.wr_addr (tgt_waddr),
		.wr_data (tgt_wdata),
		.rd_addr (raddr),
		.rd_data (tgt_rdata)
	);

	lcfe_ram #(
		.WIDTH (RGB_W),
		.DEPTH (NUM_LEDS)
	) u_cur_ram (
		.clk     (clk),
		.wr_en   (cur_we),
		.wr_addr (cur_waddr),
		.wr_data (cur_wdata),
		.rd_addr (raddr),
		.rd_data (cur_rdata)
	);

	// Fade step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= chan_t'(1);
		end else if (cfg.valid && cfg.ready) begin
			step_q <= cfg.fade_step;
		end
	end

	// Sequencer, valid bits, dirty flag and brightness
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			iss_done_q <= 1'b0;
			pend_s1    <= 1'b0;
			tgt_vld_q  <= '0;
			cur_vld_q  <= '0;
			fill_cur_q <= 1'b0;
			dirty_q    <= 1'b1;
			changed_q  <= 1'b0;
			level_q    <= chan_t'(DEFAULT_LEVEL);
		end else begin
			// read pipeline occupancy
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (load || (state_q == ST_SCAN)) begin
				pend_s1 <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						unique case (cmd.opcode)
							OP_SET_TGT: begin
								tgt_vld_q[cmd_idx] <= 1'b1;
							end
							OP_SET_IMM: begin
								tgt_vld_q[cmd_idx] <= 1'b1;
								cur_vld_q[cmd_idx] <= 1'b1;
								dirty_q            <= 1'b1;
							end
							OP_FILL_TGT, OP_FILL_IMM: begin
								fill_cur_q <= (cmd.opcode == OP_FILL_IMM);
								if (cmd.opcode == OP_FILL_IMM) begin
									dirty_q <= 1'b1;
								end
								ptr_q   <= '0;
								state_q <= ST_FILL;
							end
							OP_LEVEL: begin
								if (level_q != cmd.brightness_in) begin
									level_q <= cmd.brightness_in;
									dirty_q <= 1'b1;
								end
							end
							OP_TICK: begin
								ptr_q      <= '0;
								iss_done_q <= 1'b0;
								changed_q  <= dirty_q;
								state_q    <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FILL: begin
					tgt_vld_q[ptr_q] <= 1'b1;
					if (fill_cur_q) begin
						cur_vld_q[ptr_q] <= 1'b1;
					end
					if (ptr_q == LAST_LED) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= led_idx_t'(ptr_q + 1'b1);
					end
				end
				ST_SCAN: begin
					if (issue) begin
						if (ptr_q == LAST_LED) begin
							iss_done_q <= 1'b1;
						end else begin
							ptr_q <= led_idx_t'(ptr_q + 1'b1);
						end
					end
					// write-back side of the sweep
					if (pend_s1) begin
						cur_vld_q[addr_s1] <= 1'b1;
						if (differs) begin
							changed_q <= 1'b1;
						end
						if (addr_s1 == LAST_LED) begin
							dirty_q <= 1'b0;
							if (changed_q || differs) begin
								ptr_q      <= '0;
								iss_done_q <= 1'b0;
								state_q    <= ST_EMIT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						if (ptr_q == LAST_LED) begin
							iss_done_q <= 1'b1;
						end else begin
							ptr_q <= led_idx_t'(ptr_q + 1'b1);
						end
					end
					if (load && (addr_s1 == LAST_LED)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Read-side pipeline payload and fill color
	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= ptr_q;
		end
		tgt_vld_s1 <= tgt_vld_q[raddr];
		cur_vld_s1 <= cur_vld_q[raddr];
		if (cmd_acc) begin
			fill_rgb_q <= cmd_rgb;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_valid_q <= 1'b0;
		end else if (load) begin
			frm_valid_q <= 1'b1;
		end else if (frm.ready) begin
			frm_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			led_out_q   <= LED_OUT_W'(addr_s1);
			rgb_out_q   <= cur_eff;
			level_out_q <= level_q;
			frame_end_q <= (addr_s1 == LAST_LED);
		end
	end

	assign frm.valid     = frm_valid_q;
	assign frm.led_out   = led_out_q;
	assign frm.red_out   = rgb_out_q.r;
	assign frm.green_out = rgb_out_q.g;
	assign frm.blue_out  = rgb_out_q.b;
	assign frm.level_out = level_out_q;
	assign frm.frame_end = frame_end_q;

endmodule : led_color_fade_engine
`default_nettype wire
